>>> rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared definitions for the stuffed frame deframer
// Flag bytes, the controller state type and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	// Framing bytes of the link protocol.
	localparam logic [7:0] REPORT_BYTE   = 8'h01;
	localparam logic [7:0] SOF_BYTE      = 8'hF1;
	localparam logic [7:0] EOF_BYTE      = 8'hF2;
	localparam logic [7:0] ESCAPE_BYTE   = 8'hF3;

	// An escaped byte keeps its low two bits over a fixed upper pattern.
	localparam logic [7:0] ESC_LOW_MASK  = 8'h03;
	localparam logic [7:0] ESC_HIGH_BITS = ~ESC_LOW_MASK & 8'hF0;

	// Largest payload count reported for one frame.
	localparam logic [4:0] PAYLOAD_CAP   = 5'd28;

	typedef enum logic [3:0] {
		ST_REPORT,
		ST_START,
		ST_FRAME,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_CALC,
		ST_ONE,
		ST_PAY,
		ST_PAY_RD
	} sfd_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;      // restart hunting: drop escape, count and checksum
		logic frame_byte; // an accepted frame beat that is neither the stop flag nor an overflow
		logic rd_start;   // point the store read at entry zero
		logic rd_next;    // advance the store read pointer
		logic cap_st;     // capture the status byte
		logic cap_cmd;    // capture the command byte
		logic cap_len;    // capture the clamped payload length
		logic load_one;   // load the single result of a frame without payload
		logic load_pay;   // load one payload result
	} sfd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_report;
		logic is_start;
		logic is_stop;
		logic overflow;   // this beat would store past the end of the store
		logic xor_zero;
		logic len_zero;   // clamped length, valid in the length step
		logic pay_last;   // the payload result being loaded ends the frame
		logic out_free;   // the result register can take a new result
	} sfd_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl: deframer controller
// Hunts for the report byte and the start flag, steers frame beats into
// the datapath and sequences the store reads that build the results.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ctrl
	import sfd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     byte_valid,
	output logic          byte_ready,
	input  wire sfd_sts_t sts,
	output sfd_cmd_t      cmd
);

	sfd_state_t state_q;
	sfd_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_REPORT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_REPORT: begin
				if (byte_valid && sts.is_report) state_d = ST_START;
			end
			ST_START: begin
				if (byte_valid && sts.is_start) state_d = ST_FRAME;
			end
			ST_FRAME: begin
				if (byte_valid) begin
					priority if (sts.is_stop) begin
						state_d = sts.xor_zero ? ST_RD0 : ST_REPORT;
					end else if (sts.overflow) begin
						state_d = ST_REPORT;
					end
				end
			end
			ST_RD0:  state_d = ST_RD1;
			ST_RD1:  state_d = ST_RD2;
			ST_RD2:  state_d = ST_CALC;
			ST_CALC: state_d = sts.len_zero ? ST_ONE : ST_PAY;
			ST_ONE: begin
				if (sts.out_free) state_d = ST_REPORT;
			end
			ST_PAY: begin
				if (sts.out_free) state_d = sts.pay_last ? ST_REPORT : ST_PAY_RD;
			end
			ST_PAY_RD: state_d = ST_PAY;
			default:   state_d = ST_REPORT;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd        = '0;
		byte_ready = 1'b0;
		unique case (state_q)
			ST_REPORT: begin
				byte_ready = 1'b1;
			end
			ST_START: begin
				byte_ready = 1'b1;
				cmd.clear  = byte_valid && sts.is_start;
			end
			ST_FRAME: begin
				byte_ready = 1'b1;
				if (byte_valid) begin
					priority if (sts.is_stop) begin
						cmd.rd_start = sts.xor_zero;
						cmd.clear    = !sts.xor_zero;
					end else if (sts.overflow) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.frame_byte = 1'b1;
					end
				end
			end
			ST_RD0: begin
				cmd.rd_next = 1'b1;
			end
			ST_RD1: begin
				cmd.cap_st  = 1'b1;
				cmd.rd_next = 1'b1;
			end
			ST_RD2: begin
				cmd.cap_cmd = 1'b1;
				cmd.rd_next = 1'b1;
			end
			ST_CALC: begin
				cmd.cap_len = 1'b1;
			end
			ST_ONE: begin
				cmd.load_one = sts.out_free;
				cmd.clear    = sts.out_free;
			end
			ST_PAY: begin
				cmd.load_pay = sts.out_free;
				cmd.rd_next  = sts.out_free;
				cmd.clear    = sts.out_free && sts.pay_last;
			end
			ST_PAY_RD: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/sfd_dp.sv
// ----------------------------------------------------------------------------
// sfd_dp: deframer datapath
// Unstuffs frame beats into the frame store, keeps the running checksum,
// reads the store back and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_dp
	import sfd_pkg::*;
#(
	parameter int FRAME_MAX = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] in_byte,
	input  wire sfd_cmd_t   cmd,
	output sfd_sts_t        sts,
	input  wire logic       result_ready,
	output logic            result_valid,
	output logic [7:0]      frame_status,
	output logic [7:0]      command_byte,
	output logic [4:0]      payload_len,
	output logic [7:0]      payload_byte,
	output logic            has_payload,
	output logic            last
);

	localparam int AW = $clog2(FRAME_MAX);
	localparam int CW = $clog2(FRAME_MAX + 1);

	logic [7:0]    mem [FRAME_MAX];
	logic [CW-1:0] cnt_q;
	logic          esc_q;
	logic [7:0]    xor_q;
	logic [AW-1:0] rd_ptr_q;
	logic [7:0]    rd_data_q;
	logic [7:0]    st_q;
	logic [7:0]    cmd_q;
	logic [4:0]    len_q;
	logic [4:0]    pay_cnt_q;
	logic          out_valid_q;

	logic          takes_escape;
	logic          cnt_full;
	logic [7:0]    unstuffed;
	logic          short_frame;
	logic [CW-1:0] avail;
	logic [7:0]    avail8;
	logic [7:0]    len_avail;
	logic [7:0]    len_cap;
	logic [4:0]    len_calc;
	logic          out_free;

	// Beat decode and unstuffing.
	assign takes_escape = !esc_q && (in_byte == ESCAPE_BYTE);
	assign cnt_full     = cnt_q >= CW'(FRAME_MAX);
	assign unstuffed    = esc_q ? (ESC_HIGH_BITS | (in_byte & ESC_LOW_MASK)) : in_byte;

	// Length clamp: declared length, bytes between length and checksum, cap.
	assign short_frame = cnt_q <= CW'(2);
	assign avail       = (cnt_q > CW'(4)) ? (cnt_q - CW'(4)) : '0;
	assign avail8      = 8'(avail);
	assign len_avail   = (rd_data_q < avail8) ? rd_data_q : avail8;
	assign len_cap     = (len_avail > 8'(PAYLOAD_CAP)) ? 8'(PAYLOAD_CAP) : len_avail;
	assign len_calc    = short_frame ? 5'd0 : len_cap[4:0];

	assign out_free = !out_valid_q || result_ready;

	// Status toward the controller.
	always_comb begin
		sts.is_report = in_byte == REPORT_BYTE;
		sts.is_start  = in_byte == SOF_BYTE;
		sts.is_stop   = in_byte == EOF_BYTE;
		sts.overflow  = !takes_escape && cnt_full;
		sts.xor_zero  = xor_q == 8'h00;
		sts.len_zero  = len_calc == 5'd0;
		sts.pay_last  = (pay_cnt_q + 5'd1) == len_q;
		sts.out_free  = out_free;
	end

	// Escape flag, byte count and running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			cnt_q <= '0;
			xor_q <= 8'h00;
		end else if (cmd.clear) begin
			esc_q <= 1'b0;
			cnt_q <= '0;
			xor_q <= 8'h00;
		end else if (cmd.frame_byte) begin
			if (takes_escape) begin
				esc_q <= 1'b1;
			end else begin
				esc_q <= 1'b0;
				cnt_q <= cnt_q + CW'(1);
				xor_q <= xor_q ^ unstuffed;
			end
		end
	end

	// Frame store: one write port at the byte count, one registered read.
	always_ff @(posedge clk) begin
		if (cmd.frame_byte && !takes_escape && !cnt_full) begin
			mem[cnt_q[AW-1:0]] <= unstuffed;
		end
		rd_data_q <= mem[rd_ptr_q];
	end

	// Read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
		end else if (cmd.rd_start) begin
			rd_ptr_q <= '0;
		end else if (cmd.rd_next) begin
			rd_ptr_q <= rd_ptr_q + AW'(1);
		end
	end

	// Header fields captured from the store.
	always_ff @(posedge clk) begin
		if (cmd.cap_st) st_q <= (cnt_q == '0) ? 8'h00 : rd_data_q;
		if (cmd.cap_cmd) cmd_q <= short_frame ? 8'h00 : rd_data_q;
		if (cmd.cap_len) len_q <= len_calc;
	end

	// Payload result counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pay_cnt_q <= '0;
		end else if (cmd.cap_len) begin
			pay_cnt_q <= '0;
		end else if (cmd.load_pay) begin
			pay_cnt_q <= pay_cnt_q + 5'd1;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_one || cmd.load_pay) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register fields.
	always_ff @(posedge clk) begin
		if (cmd.load_one) begin
			frame_status <= st_q;
			command_byte <= cmd_q;
			payload_len  <= 5'd0;
			payload_byte <= 8'h00;
			has_payload  <= 1'b0;
			last         <= 1'b1;
		end else if (cmd.load_pay) begin
			frame_status <= st_q;
			command_byte <= cmd_q;
			payload_len  <= len_q;
			payload_byte <= rd_data_q;
			has_payload  <= 1'b1;
			last         <= (pay_cnt_q + 5'd1) == len_q;
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/stuffed_frame_deframer.sv
// ----------------------------------------------------------------------------
// stuffed_frame_deframer: byte-serial deframer for stuffed, XOR-checked frames
// Hunts for the report byte and start flag, unstuffs frame bytes into a store
// and, on a stop flag with a zero checksum, emits header and payload results.
//
//   Channel  Handshake                    Beat contents
//   byte     byte_valid / byte_ready      in_byte
//   result   result_valid / result_ready  frame_status, command_byte,
//                                         payload_len, payload_byte,
//                                         has_payload, last
//
// Input is held off after a stop flag with a zero checksum: through the
// header reads, then for each payload result a load and a store read on the
// single registered read port, a load alone for the last result
// (a frame without payload gives one result).
// Reset clears hunt state, counters and result valid, not the store.
// A stalled result holds the load in place; input resumes after the last load.
// ----------------------------------------------------------------------------
`default_nettype none

module stuffed_frame_deframer
	import sfd_pkg::*;
#(
	parameter int FRAME_MAX = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire logic [7:0] in_byte,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [7:0]      frame_status,
	output logic [7:0]      command_byte,
	output logic [4:0]      payload_len,
	output logic [7:0]      payload_byte,
	output logic            has_payload,
	output logic            last
);

	sfd_cmd_t cmd;
	sfd_sts_t sts;

	// Controller.
	sfd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// Datapath.
	sfd_dp #(
		.FRAME_MAX (FRAME_MAX)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.cmd          (cmd),
		.sts          (sts),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.frame_status (frame_status),
		.command_byte (command_byte),
		.payload_len  (payload_len),
		.payload_byte (payload_byte),
		.has_payload  (has_payload),
		.last         (last)
	);

endmodule

`default_nettype wire
